// ===== rtl/core/mwom_pkg.sv =====
// ----------------------------------------------------------------------------
// mwom_pkg
// Shared types and constants for the multi-wave oscillator mixer.
// ----------------------------------------------------------------------------
package mwom_pkg;

    localparam int WAVE_BITS  = 10;
    localparam int GAIN_BITS  = 17;
    localparam int MIX_BITS   = 24;
    localparam int THR_BITS   = 24;
    localparam int SAW_BITS   = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [GAIN_BITS-1:0] GAIN_MAX   = 17'd65536;
    localparam logic [THR_BITS-1:0]  THR_MAX    = 24'hFFFFFF;
    localparam logic [THR_BITS-1:0]  THR_RESET  = 24'h800000;
    localparam logic [7:0]           SAW_OFFSET = 8'h70;
    localparam logic [15:0]          THR_ROUND  = 16'h8000;

    // wave modes
    localparam logic [1:0] MODE_SAW   = 2'd0;
    localparam logic [1:0] MODE_TRI   = 2'd1;
    localparam logic [1:0] MODE_PULSE = 2'd2;
    localparam logic [1:0] MODE_IDLE  = 2'd3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WAVE_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_STEP  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LVOL_START  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RVOL_START  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LVOL_STEP   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RVOL_STEP   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_THR_START   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_THR_STEP    = 3'd7;

    typedef struct packed {
        logic signed [WAVE_BITS-1:0] wave;
        logic [GAIN_BITS-1:0]        left_gain;
        logic [GAIN_BITS-1:0]        right_gain;
        logic signed [MIX_BITS-1:0]  mix_left;
        logic signed [MIX_BITS-1:0]  mix_right;
    } t_mix_item;

endpackage

// ===== rtl/core/multi_wave_oscillator_mixer.sv =====
// ----------------------------------------------------------------------------
// multi_wave_oscillator_mixer
// Phase accumulator oscillator (saw, triangle, pulse) whose sample is scaled
// by ramping stereo gains and added with saturation to an incoming mix.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  config   | i_cfg_we                   | i_cfg_addr, i_cfg_data
//  sample   | i_in_valid / o_in_ready    | i_restart, i_mix_in_left/right
//  result   | o_out_valid / i_out_ready  | o_mix_out_left/right, o_wave_value
//
//  one transaction per cycle sustained while the result is not stalled; an input
//  transaction reaches result valid through the queue write at the accepting
//  edge, then the product stage and the output register
//  the oscillator state updates once per accepted sample in the front part
//  reset clears registers to their defaults and empties the queue and pipeline
//  a stalled result holds the back part; the front keeps taking samples until
//  the two-entry queue fills, then o_in_ready drops
// ----------------------------------------------------------------------------
module multi_wave_oscillator_mixer import mwom_pkg::*; #(
    parameter int PHASE_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_restart,
    input  logic signed [MIX_BITS-1:0]  i_mix_in_left,
    input  logic signed [MIX_BITS-1:0]  i_mix_in_right,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [MIX_BITS-1:0]  o_mix_out_left,
    output logic signed [MIX_BITS-1:0]  o_mix_out_right,
    output logic signed [WAVE_BITS-1:0] o_wave_value
);

    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    t_mix_item front_item;
    t_mix_item queue_item;

    mwom_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .i_mix_in_left  (i_mix_in_left),
        .i_mix_in_right (i_mix_in_right),
        .i_full         (full),
        .o_push         (push),
        .o_item         (front_item)
    );

    mwom_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    mwom_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_item          (queue_item),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_mix_out_left  (o_mix_out_left),
        .o_mix_out_right (o_mix_out_right),
        .o_wave_value    (o_wave_value)
    );

endmodule

// ===== rtl/core/mwom_front.sv =====
// ----------------------------------------------------------------------------
// mwom_front
// Register file, phase accumulator, waveform generation and gain/threshold
// ramps. One accepted sample per cycle is pushed into the mix queue while it is not full.
// ----------------------------------------------------------------------------
module mwom_front import mwom_pkg::*; #(
    parameter int PHASE_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_restart,
    input  logic signed [MIX_BITS-1:0]   i_mix_in_left,
    input  logic signed [MIX_BITS-1:0]   i_mix_in_right,
    input  logic                         i_full,
    output logic                         o_push,
    output t_mix_item                    o_item
);

    localparam int PAD_BITS = 64 - PHASE_BITS;

    logic [1:0]                  r_wave_mode;
    logic [23:0]                 r_phase_step;
    logic [GAIN_BITS-1:0]        r_lvol_start;
    logic [GAIN_BITS-1:0]        r_rvol_start;
    logic signed [17:0]          r_lvol_step;
    logic signed [17:0]          r_rvol_step;
    logic [THR_BITS-1:0]         r_thr_start;
    logic signed [THR_BITS-1:0]  r_thr_step;

    logic [PHASE_BITS-1:0]       r_phase;
    logic [SAW_BITS-1:0]         r_saw;
    logic [GAIN_BITS-1:0]        r_left_gain;
    logic [GAIN_BITS-1:0]        r_right_gain;
    logic [THR_BITS-1:0]         r_thr;

    logic [PHASE_BITS-1:0]       n_phase;
    logic [SAW_BITS-1:0]         n_saw;
    logic [GAIN_BITS-1:0]        n_left_gain;
    logic [GAIN_BITS-1:0]        n_right_gain;
    logic [THR_BITS-1:0]         n_thr;

    logic [PHASE_BITS-1:0]       cur_phase;
    logic [SAW_BITS-1:0]         cur_saw;
    logic [GAIN_BITS-1:0]        cur_lgain;
    logic [GAIN_BITS-1:0]        cur_rgain;
    logic [THR_BITS-1:0]         cur_thr;
    logic [PHASE_BITS-1:0]       adv_phase;
    logic [PHASE_BITS-1:0]       sel_phase;
    logic [63:0]                 ph_al;
    logic [SAW_BITS-1:0]         saw_h;
    logic [9:0]                  tri_t;
    logic signed [10:0]          tri_w;
    logic [8:0]                  thr_dc;
    logic signed [10:0]          pul_w;
    logic signed [WAVE_BITS-1:0] wave;
    logic signed [25:0]          thr_sum;
    logic                        push;

    function automatic logic [GAIN_BITS-1:0] gain_ramp(
        input logic [GAIN_BITS-1:0] gain,
        input logic signed [17:0]   step
    );
        logic signed [19:0] sum;
        sum = $signed({3'b000, gain}) + 20'(step);
        if (sum < 20'sd0)
            return '0;
        else if (sum > $signed({3'b000, GAIN_MAX}))
            return GAIN_MAX;
        else
            return sum[GAIN_BITS-1:0];
    endfunction

    assign push       = i_in_valid && !i_full;
    assign o_push     = push;
    assign o_in_ready = !i_full;

    always_comb begin
        cur_phase = i_restart ? '0 : r_phase;
        cur_saw   = i_restart ? '0 : r_saw;
        cur_lgain = i_restart ? ((r_lvol_start > GAIN_MAX) ? GAIN_MAX : r_lvol_start)
                              : r_left_gain;
        cur_rgain = i_restart ? ((r_rvol_start > GAIN_MAX) ? GAIN_MAX : r_rvol_start)
                              : r_right_gain;
        cur_thr   = i_restart ? r_thr_start : r_thr;

        adv_phase = cur_phase + PHASE_BITS'(r_phase_step);
        // pulse mode reads the phase before advancing it
        sel_phase = (r_wave_mode == MODE_PULSE) ? cur_phase : adv_phase;
        ph_al     = {sel_phase, {PAD_BITS{1'b0}}};

        // integer saw: top byte minus offset minus 5 mid bits plus half of history
        saw_h = 32'(ph_al[63:56]) - 32'(SAW_OFFSET) - 32'(ph_al[62:58])
              + {cur_saw[31], cur_saw[31:1]};

        tri_t = ph_al[63:54];
        if (!tri_t[9])
            tri_w = $signed({1'b0, tri_t}) - 11'sd256;
        else
            tri_w = 11'sd768 - $signed({1'b0, tri_t});

        thr_dc = 9'((25'(cur_thr) + 25'(THR_ROUND)) >> 16);
        pul_w  = ((ph_al[63:40] < cur_thr) ? 11'sd256 : 11'sd0) - $signed({2'b00, thr_dc});

        case (r_wave_mode)
            MODE_SAW: begin
                if ($signed(saw_h) < -32'sd512)
                    wave = -10'sd512;
                else if ($signed(saw_h) > 32'sd511)
                    wave = 10'sd511;
                else
                    wave = $signed(saw_h[WAVE_BITS-1:0]);
            end
            MODE_TRI:   wave = tri_w[WAVE_BITS-1:0];
            MODE_PULSE: wave = pul_w[WAVE_BITS-1:0];
            default:    wave = '0;
        endcase

        thr_sum = $signed({2'b00, cur_thr}) + 26'(r_thr_step);

        n_phase      = (r_wave_mode == MODE_IDLE) ? cur_phase : adv_phase;
        n_saw        = (r_wave_mode == MODE_SAW) ? saw_h : cur_saw;
        n_left_gain  = gain_ramp(cur_lgain, r_lvol_step);
        n_right_gain = gain_ramp(cur_rgain, r_rvol_step);
        if (r_wave_mode != MODE_PULSE)
            n_thr = cur_thr;
        else if (thr_sum < 26'sd0)
            n_thr = '0;
        else if (thr_sum > $signed({2'b00, THR_MAX}))
            n_thr = THR_MAX;
        else
            n_thr = thr_sum[THR_BITS-1:0];
    end

    always_comb begin
        o_item.wave       = wave;
        o_item.left_gain  = cur_lgain;
        o_item.right_gain = cur_rgain;
        o_item.mix_left   = i_mix_in_left;
        o_item.mix_right  = i_mix_in_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode  <= MODE_SAW;
            r_phase_step <= '0;
            r_lvol_start <= '0;
            r_rvol_start <= '0;
            r_lvol_step  <= '0;
            r_rvol_step  <= '0;
            r_thr_start  <= THR_RESET;
            r_thr_step   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WAVE_MODE:  r_wave_mode  <= i_cfg_data[1:0];
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                CFG_LVOL_START: r_lvol_start <= i_cfg_data[GAIN_BITS-1:0];
                CFG_RVOL_START: r_rvol_start <= i_cfg_data[GAIN_BITS-1:0];
                CFG_LVOL_STEP:  r_lvol_step  <= $signed(i_cfg_data[17:0]);
                CFG_RVOL_STEP:  r_rvol_step  <= $signed(i_cfg_data[17:0]);
                CFG_THR_START:  r_thr_start  <= i_cfg_data;
                CFG_THR_STEP:   r_thr_step   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_saw        <= '0;
            r_left_gain  <= '0;
            r_right_gain <= '0;
            r_thr        <= THR_RESET;
        end else if (push) begin
            r_phase      <= n_phase;
            r_saw        <= n_saw;
            r_left_gain  <= n_left_gain;
            r_right_gain <= n_right_gain;
            r_thr        <= n_thr;
        end
    end

    a_left_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left_gain <= GAIN_MAX && r_right_gain <= GAIN_MAX)
        else $error("gain ramp left its range");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_full |=> $stable(r_phase) && $stable(r_saw))
        else $error("oscillator state moved while queue was full");

endmodule

// ===== rtl/core/mwom_queue.sv =====
// ----------------------------------------------------------------------------
// mwom_queue
// Two-entry queue of waveform samples between the front and the mixer.
// ----------------------------------------------------------------------------
module mwom_queue import mwom_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_mix_item i_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_empty,
    output t_mix_item o_item
);

    t_mix_item           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full)
            r_mem[r_wr_ptr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full)
                r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)
                r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push && !o_full, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

// ===== rtl/core/mwom_back.sv =====
// ----------------------------------------------------------------------------
// mwom_back
// Mixer: wave times gain in one stage, then rounding, mix add and saturation
// into the output register.
// ----------------------------------------------------------------------------
module mwom_back import mwom_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  t_mix_item                     i_item,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [MIX_BITS-1:0]    o_mix_out_left,
    output logic signed [MIX_BITS-1:0]    o_mix_out_right,
    output logic signed [WAVE_BITS-1:0]   o_wave_value
);

    localparam int PROD_BITS = WAVE_BITS + GAIN_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 1;

    logic                          r_s1_valid;
    logic signed [PROD_BITS-1:0]   r_s1_prod_l;
    logic signed [PROD_BITS-1:0]   r_s1_prod_r;
    logic signed [MIX_BITS-1:0]    r_s1_mix_l;
    logic signed [MIX_BITS-1:0]    r_s1_mix_r;
    logic signed [WAVE_BITS-1:0]   r_s1_wave;

    logic                          r_out_valid;
    logic signed [MIX_BITS-1:0]    r_out_l;
    logic signed [MIX_BITS-1:0]    r_out_r;
    logic signed [WAVE_BITS-1:0]   r_out_wave;

    logic                          s2_take;
    logic                          s1_take;
    logic signed [MIX_BITS-1:0]    n_out_l;
    logic signed [MIX_BITS-1:0]    n_out_r;

    function automatic logic signed [MIX_BITS-1:0] mix_sat(
        input logic signed [PROD_BITS-1:0] prod,
        input logic signed [MIX_BITS-1:0]  mix
    );
        logic signed [PROD_BITS-1:0] q;
        logic signed [SUM_BITS-1:0]  s;
        // round to nearest, ties up, then floor by 256
        q = (prod + PROD_BITS'(128)) >>> 8;
        s = SUM_BITS'(mix) + SUM_BITS'(q);
        if (s < -SUM_BITS'(24'sh800000 * 0 + 8388608))
            return {1'b1, {(MIX_BITS-1){1'b0}}};
        else if (s > SUM_BITS'(8388607))
            return {1'b0, {(MIX_BITS-1){1'b1}}};
        else
            return s[MIX_BITS-1:0];
    endfunction

    assign s2_take = !r_out_valid || i_out_ready;
    assign s1_take = !r_s1_valid || s2_take;
    assign o_pop   = s1_take && !i_empty;

    assign n_out_l = mix_sat(r_s1_prod_l, r_s1_mix_l);
    assign n_out_r = mix_sat(r_s1_prod_r, r_s1_mix_r);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_prod_l <= i_item.wave * $signed({1'b0, i_item.left_gain});
            r_s1_prod_r <= i_item.wave * $signed({1'b0, i_item.right_gain});
            r_s1_mix_l  <= i_item.mix_left;
            r_s1_mix_r  <= i_item.mix_right;
            r_s1_wave   <= i_item.wave;
        end
        if (r_s1_valid && s2_take) begin
            r_out_l    <= n_out_l;
            r_out_r    <= n_out_r;
            r_out_wave <= r_s1_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_take)
                r_s1_valid <= !i_empty;
            if (s2_take)
                r_out_valid <= r_s1_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mix_out_left  = r_out_l;
    assign o_mix_out_right = r_out_r;
    assign o_wave_value    = r_out_wave;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_take |=> r_s1_valid && $stable(r_s1_prod_l)
                                   && $stable(r_s1_prod_r))
        else $error("product stage changed while stalled");

endmodule
